/* src/ocavg_pkg.sv */
// Shared widths, constants, codes and types for the oscillator count averager.
// Used by every module of the block; depends on nothing.
package ocavg_pkg;

  localparam int CNT_W = 16;
  localparam int SUM_W = 20;
  localparam int PER_W = 4;
  localparam int LIM_W = 16;
  localparam int KHZ_W = 22;
  localparam int TOT_W = 26;
  localparam int DVD_W = 26;
  localparam int DVS_W = 10;
  localparam int DCNT_W = 5;
  localparam int SCALE_SHIFT = 15;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // floor(a * 32768 / 1000) == (a * (2**RECIP_HI + RECIP_LO)) >> RECIP_SHIFT
  // for every a below 2**SUM_W.
  localparam int RECIP_W = 27;
  localparam int RECIP_HI = 32;
  localparam int RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP_LO = 27'd103079216;

  localparam logic [DVS_W-1:0] SCALE_DIV = 10'd1000;
  localparam logic [CNT_W-1:0] MAX_SEED = 16'd1;
  localparam logic [CNT_W-1:0] MIN_SEED = 16'd4000;
  localparam logic [PER_W-1:0] OSC_PERIODS_RST = 4'd4;
  localparam logic [LIM_W-1:0] SPREAD_LIMIT_RST = 16'd50;

  localparam logic [CFG_IDX_W-1:0] CFG_OSC_PERIODS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT = 1'b1;

  // One finished round, handed from front to back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             rejected;
    logic [PER_W-1:0] periods;
  } rec_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [KHZ_W-1:0] round_khz;
    logic             round_rejected;
    logic             run_done;
    logic [KHZ_W-1:0] average_khz;
    logic             all_rejected;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CH,
    BK_SCL,
    BK_RUN,
    BK_AVG,
    BK_OUT
  } bk_state_e;

endpackage

/* src/ocavg_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ocavg_pkg for widths and the request/response structs.
module ocavg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ocavg_pkg::div_req_t req_i,
  output ocavg_pkg::div_rsp_t rsp_o
);
  import ocavg_pkg::*;

  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Subtract when the partial remainder reaches the divisor.
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* src/ocavg_front.sv */
// Front end: accepts counts, keeps per-round sum, max and min, and
// classifies each finished round. Depends on ocavg_pkg.
module ocavg_front #(
  parameter int CHANNELS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [ocavg_pkg::CNT_W-1:0]        count_i,
  input  logic [ocavg_pkg::PER_W-1:0]        osc_periods_i,
  input  logic [ocavg_pkg::LIM_W-1:0]        spread_limit_i,
  input  logic                               full_i,
  output logic                               push_o,
  output ocavg_pkg::rec_t                    rec_o
);
  import ocavg_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] LastCh = CW'(CHANNELS - 1);

  logic [CW-1:0]    ch_q, ch_d;
  logic [SUM_W-1:0] sum_q, sum_d, sum_nxt;
  logic [CNT_W-1:0] max_q, max_d, max_nxt;
  logic [CNT_W-1:0] min_q, min_d, min_nxt;
  logic [CNT_W-1:0] spread;
  logic             accept;
  logic             last_ch;

  assign s_axis_tready_o = !full_i;
  assign accept  = s_axis_tvalid_i && !full_i;
  assign last_ch = (ch_q == LastCh);

  assign sum_nxt = sum_q + SUM_W'(count_i);
  assign max_nxt = (count_i > max_q) ? count_i : max_q;
  assign min_nxt = (count_i < min_q) ? count_i : min_q;
  assign spread  = max_nxt - min_nxt;

  assign push_o         = accept && last_ch;
  assign rec_o.sum      = sum_nxt;
  assign rec_o.rejected = (spread > spread_limit_i);
  assign rec_o.periods  = osc_periods_i;

  always_comb begin
    ch_d  = ch_q;
    sum_d = sum_q;
    max_d = max_q;
    min_d = min_q;
    if (accept) begin
      if (last_ch) begin
        ch_d  = '0;
        sum_d = '0;
        max_d = MAX_SEED;
        min_d = MIN_SEED;
      end else begin
        ch_d  = ch_q + 1'b1;
        sum_d = sum_nxt;
        max_d = max_nxt;
        min_d = min_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= '0;
      sum_q <= '0;
      max_q <= MAX_SEED;
      min_q <= MIN_SEED;
    end else begin
      ch_q  <= ch_d;
      sum_q <= sum_d;
      max_q <= max_d;
      min_q <= min_d;
    end
  end

endmodule

/* src/ocavg_fifo.sv */
// Two-entry round queue between front and back.
// Depends on ocavg_pkg for the round record type.
module ocavg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ocavg_pkg::rec_t wdata_i,
  input  logic            pop_i,
  output ocavg_pkg::rec_t rdata_o,
  output logic            empty_o,
  output logic            full_o
);
  import ocavg_pkg::*;

  rec_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      priority case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

/* src/ocavg_back.sv */
// Back end: averages each good round in a shared serial divider, scales it, keeps
// the run total, and registers one result per round. Depends on ocavg_pkg.
module ocavg_back #(
  parameter int CHANNELS = 12,
  parameter int ROUNDS   = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ocavg_pkg::rec_t rec_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ocavg_pkg::res_t res_o
);
  import ocavg_pkg::*;

  localparam int RW = $clog2(ROUNDS + 1);
  localparam int PW = SUM_W + RECIP_W;
  localparam int SW = SUM_W + RECIP_HI + 1;
  localparam logic [DVS_W-1:0] ChDvs = DVS_W'(CHANNELS);

  bk_state_e        state_q, state_d;
  rec_t             rec_q, rec_d;
  logic [SUM_W-1:0] avga_q, avga_d;
  logic [KHZ_W-1:0] khz_q, khz_d;
  logic [KHZ_W-1:0] avg_q, avg_d;
  logic             none_q, none_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [RW-1:0]    rnd_q, rnd_d;
  logic [RW-1:0]    rej_q, rej_d;
  logic [RW-1:0]    seen;
  logic [RW-1:0]    good;
  logic             last_round;
  logic [PER_W-1:0] per_eff;
  logic [PW-1:0]    recip_prod;
  logic [SW-1:0]    scl_sum;
  logic [KHZ_W-1:0] scl_khz;
  logic             out_load;
  logic             out_valid_q;
  res_t             res_q;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  ocavg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign seen       = rnd_q + 1'b1;
  assign good       = seen - rej_q;
  assign last_round = (seen >= RW'(ROUNDS));
  assign per_eff    = (rec_i.periods == '0) ? PER_W'(1) : rec_i.periods;

  // Scale by 32768 / 1000 through a reciprocal multiply and a shift.
  assign recip_prod = PW'(avga_q) * PW'(RECIP_LO);
  assign scl_sum    = {1'b0, avga_q, {RECIP_HI{1'b0}}} + SW'(recip_prod);
  assign scl_khz    = scl_sum[RECIP_SHIFT +: KHZ_W];

  always_comb begin
    state_d          = state_q;
    rec_d            = rec_q;
    avga_d           = avga_q;
    khz_d            = khz_q;
    avg_d            = avg_q;
    none_d           = none_q;
    total_d          = total_q;
    rnd_d            = rnd_q;
    rej_d            = rej_q;
    pop_o            = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DVS_W'(1);
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          rec_d = rec_i;
          if (rec_i.rejected) begin
            khz_d   = '0;
            rej_d   = rej_q + 1'b1;
            state_d = BK_RUN;
          end else begin
            // Channel average and period count in one division.
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(rec_i.sum);
            div_req.divisor  = ChDvs * DVS_W'(per_eff);
            state_d          = BK_CH;
          end
        end
      end
      BK_CH: begin
        if (div_rsp.done) begin
          avga_d  = div_rsp.quotient[SUM_W-1:0];
          state_d = BK_SCL;
        end
      end
      BK_SCL: begin
        khz_d   = scl_khz;
        state_d = BK_RUN;
      end
      BK_RUN: begin
        avg_d  = '0;
        none_d = 1'b0;
        if (!rec_q.rejected) total_d = total_q + TOT_W'(khz_q);
        if (last_round) begin
          if (rej_q >= seen) begin
            none_d  = 1'b1;
            state_d = BK_OUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(total_d);
            div_req.divisor  = DVS_W'(good);
            state_d          = BK_AVG;
          end
        end else begin
          state_d = BK_OUT;
        end
      end
      BK_AVG: begin
        if (div_rsp.done) begin
          avg_d   = div_rsp.quotient[KHZ_W-1:0];
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (last_round) begin
            rnd_d   = '0;
            rej_d   = '0;
            total_d = '0;
          end else begin
            rnd_d = rnd_q + 1'b1;
          end
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      total_q     <= '0;
      rnd_q       <= '0;
      rej_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      rnd_q   <= rnd_d;
      rej_q   <= rej_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    avga_q <= avga_d;
    khz_q  <= khz_d;
    avg_q  <= avg_d;
    none_q <= none_d;
    if (out_load) begin
      res_q.round_khz      <= khz_q;
      res_q.round_rejected <= rec_q.rejected;
      res_q.run_done       <= last_round;
      res_q.average_khz    <= avg_q;
      res_q.all_rejected   <= none_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && rec_q.rejected) |=> (res_o.round_khz == '0))
    else $error("rejected round gave nonzero frequency");

  a_mid_run_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.run_done) |-> (res_o.average_khz == '0 && !res_o.all_rejected))
    else $error("average reported before end of run");

  a_pop_in_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BK_IDLE && !empty_i))
    else $error("queue popped outside idle");

endmodule

/* src/osc_count_calibration_averager.sv */
// Top level of the oscillator count calibration averager: configuration
// registers, front end, round queue and back end. Depends on ocavg_pkg.
//
// Usage: per-channel counts enter on the s_axis channel, CHANNELS to a round,
// ROUNDS rounds to a run. Each accepted count is one transaction; the last
// count of a round produces exactly one result transaction on m_axis, and
// other counts produce none. m_axis_tlast_o marks the result of the last
// round of a run, which also carries the run average.
// Counts are taken one per cycle while the two-entry round queue has room.
// The back end runs a restoring divider. A good round needs one division and
// one scaling step before its result is registered; a rejected round skips both.
// The last round of a run adds the average division. The back end takes a new
// round from the queue only after the result of the last one is loaded, so
// sustained throughput is set by the serial divider.
// The result sits in an output register; while the receiver stalls the back
// end finishes its current round and holds, then the queue fills and
// s_axis_tready_o drops. Reset clears the round and run state and loads
// osc_periods with 4 and spread_limit with 50. Write the configuration
// through cfg_we_i only while the block is idle.
module osc_count_calibration_averager #(
  parameter int CHANNELS = 12,
  parameter int ROUNDS   = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [15:0]                       s_axis_tdata_i,  // [15:0] count
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [21:0] round_khz, [22] round_rejected, [44:23] average_khz,
  // [45] all_rejected, [47:46] zero
  output logic [47:0]                       m_axis_tdata_o,
  output logic                              m_axis_tlast_o,  // run_done
  input  logic                              cfg_we_i,
  input  logic [ocavg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ocavg_pkg::CFG_DAT_W-1:0]   cfg_wdata_i
);
  import ocavg_pkg::*;

  logic [PER_W-1:0] osc_periods_q;
  logic [LIM_W-1:0] spread_limit_q;
  logic             push;
  logic             pop;
  logic             empty;
  logic             full;
  rec_t             rec_in;
  rec_t             rec_out;
  res_t             res;

  // Configuration writes take effect at the next edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_periods_q  <= OSC_PERIODS_RST;
      spread_limit_q <= SPREAD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OSC_PERIODS:  osc_periods_q  <= cfg_wdata_i[PER_W-1:0];
        CFG_SPREAD_LIMIT: spread_limit_q <= cfg_wdata_i[LIM_W-1:0];
        default:          ;
      endcase
    end
  end

  // Accumulate counts and classify each round.
  ocavg_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .count_i         (s_axis_tdata_i),
    .osc_periods_i   (osc_periods_q),
    .spread_limit_i  (spread_limit_q),
    .full_i          (full),
    .push_o          (push),
    .rec_o           (rec_in)
  );

  // Buffer finished rounds so the front keeps taking counts.
  ocavg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_in),
    .pop_i   (pop),
    .rdata_o (rec_out),
    .empty_o (empty),
    .full_o  (full)
  );

  // Scale, total and average; hold the result until taken.
  ocavg_back #(
    .CHANNELS (CHANNELS),
    .ROUNDS   (ROUNDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {2'b00, res.all_rejected, res.average_khz,
                           res.round_rejected, res.round_khz};
  assign m_axis_tlast_o = res.run_done;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for osc_count_calibration_averager: drives channel counts on the
// input stream, predicts each round result in-bench and checks the output stream.
// Depends on ocavg_pkg and the block's top level only.
module tb;
  import ocavg_pkg::*;

  localparam int CHANNELS = 12;
  localparam int ROUNDS   = 20;
  localparam int RUN_LEN  = CHANNELS * ROUNDS;
  localparam int SETTLE   = 250;
  localparam int PHASES   = 8;
  localparam longint unsigned SCALE_MUL = 64'd1 << SCALE_SHIFT;
  localparam longint unsigned SCALE_DEN = SCALE_DIV;

  // How the counts of one round are shaped.
  typedef enum logic [2:0] {
    MODE_LOW_CLUSTER,   // near a center below the min seed, spread near the limit
    MODE_WIDE_CLUSTER,  // tight around any center
    MODE_NOISE,         // full-range random
    MODE_FLAT,          // one value for the whole round
    MODE_RAILS,         // only 0 and 65535
    MODE_REJECT         // random with a zero count somewhere
  } round_mode_e;

  typedef struct {
    logic [15:0] count;
    bit          typed;
    res_t        want;
  } row_t;

  // Clock, reset and block inputs; every input holds a known value from time 0.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 s_tvalid  = 1'b0;
  logic [15:0]          s_tdata   = '0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic        m_tlast;

  // Predictor state: round and run accumulators plus the shadow registers.
  logic [3:0]       chan_idx    = '0;
  logic [4:0]       rnd_idx     = '0;
  logic [SUM_W-1:0] acc_sum     = '0;
  logic [CNT_W-1:0] hi_cnt      = MAX_SEED;
  logic [CNT_W-1:0] lo_cnt      = MIN_SEED;
  logic [TOT_W-1:0] khz_total   = '0;
  logic [4:0]       bad_rounds  = '0;
  logic [PER_W-1:0] periods_cfg = OSC_PERIODS_RST;
  logic [LIM_W-1:0] spread_cfg  = SPREAD_LIMIT_RST;

  res_t round_q[$];  // round results still owed by the block

  // Stimulus shaping.
  round_mode_e round_mode  = MODE_NOISE;
  int          center      = 0;
  int          half_width  = 0;
  int          zero_chan   = 0;
  bit          reject_phase = 1'b0;
  bit          s_burst     = 1'b0;
  bit          m_burst     = 1'b0;

  // Bookkeeping for the summary.
  int n_errors   = 0;
  int n_counts   = 0;
  int n_results  = 0;
  int n_rejected = 0;
  int n_runs     = 0;
  int n_allrej   = 0;
  int n_settings = 0;

  // Directed rows: one flat round at the min seed, then one round on both rails.
  // 12 x 4000 with reset periods 4: (48000/12)/4 = 1000, scaled to 32768.
  // 65535 and 0 in one round exceed the reset spread limit of 50.
  row_t dir_tab [24] = '{
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b0, '0},
    '{16'd4000, 1'b1, '{22'd32768, 1'b0, 1'b0, 22'd0, 1'b0}},
    '{16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b1, '{22'd0, 1'b1, 1'b0, 22'd0, 1'b0}}
  };

  osc_count_calibration_averager #(
    .CHANNELS(CHANNELS),
    .ROUNDS  (ROUNDS)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fold one count into the round; return 1 and the round result on the last channel.
  function automatic bit fold_count(input logic [15:0] c, output res_t r);
    int unsigned divisor;
    int unsigned chan_avg;
    int unsigned good;
    int unsigned avg;
    longint unsigned scaled;
    r = '0;
    acc_sum = acc_sum + SUM_W'(c);
    if (c > hi_cnt) hi_cnt = c;
    if (c < lo_cnt) lo_cnt = c;
    if (int'(chan_idx) + 1 < CHANNELS) begin
      chan_idx = chan_idx + 4'd1;
      return 1'b0;
    end
    // Hold the round against the limit; only a good round adds to the run.
    r.round_rejected = (int'(hi_cnt) - int'(lo_cnt)) > int'(spread_cfg);
    if (r.round_rejected) begin
      bad_rounds = bad_rounds + 5'd1;
    end else begin
      divisor  = (periods_cfg == '0) ? 1 : int'(periods_cfg);
      chan_avg = (int'(acc_sum) / CHANNELS) / divisor;
      scaled   = (longint'(chan_avg) * SCALE_MUL) / SCALE_DEN;
      r.round_khz = scaled[KHZ_W-1:0];
      khz_total = khz_total + TOT_W'(r.round_khz);
    end
    chan_idx = '0;
    acc_sum  = '0;
    hi_cnt   = MAX_SEED;
    lo_cnt   = MIN_SEED;
    r.run_done = (int'(rnd_idx) + 1 >= ROUNDS);
    if (r.run_done) begin
      good = int'(rnd_idx) + 1 - int'(bad_rounds);
      if (int'(bad_rounds) >= int'(rnd_idx) + 1) begin
        r.all_rejected = 1'b1;
      end else begin
        avg = int'(khz_total) / good;
        r.average_khz = avg[KHZ_W-1:0];
      end
      rnd_idx    = '0;
      khz_total  = '0;
      bad_rounds = '0;
    end else begin
      rnd_idx = rnd_idx + 5'd1;
    end
    return 1'b1;
  endfunction

  // Draw the next random count; pick the shape of a round on its first channel.
  function automatic logic [15:0] next_count();
    int v;
    int pick;
    if (chan_idx == '0) begin
      if (reject_phase) begin
        round_mode = MODE_REJECT;
        zero_chan  = $urandom_range(0, CHANNELS - 1);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          round_mode = MODE_LOW_CLUSTER;
          center     = $urandom_range(0, MIN_SEED);
          half_width = $urandom_range(0, spread_cfg / 2 + 10);
        end else if (pick < 7) begin
          round_mode = MODE_WIDE_CLUSTER;
          center     = $urandom_range(0, 65535);
          half_width = $urandom_range(0, 40);
        end else if (pick == 7) begin
          round_mode = MODE_NOISE;
        end else if (pick == 8) begin
          round_mode = MODE_FLAT;
          case ($urandom_range(0, 3))
            0:       center = 0;
            1:       center = 1;
            2:       center = MIN_SEED;
            default: center = 65535;
          endcase
        end else begin
          round_mode = MODE_RAILS;
        end
      end
    end
    case (round_mode)
      MODE_LOW_CLUSTER, MODE_WIDE_CLUSTER:
        v = center + int'($urandom_range(0, 2 * half_width)) - half_width;
      MODE_FLAT:   v = center;
      MODE_RAILS:  v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
      MODE_REJECT: v = (int'(chan_idx) == zero_chan) ? 0 : $urandom_range(0, 65535);
      default:     v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    n_errors++;
    if (n_errors <= 50)
      $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one count after a random gap, wait for the transaction, then predict.
  task automatic send_count(input logic [15:0] c, input bit typed, input res_t want);
    int   gap;
    res_t pred;
    if ($urandom_range(0, 31) == 0) s_burst = ~s_burst;
    gap = s_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    n_counts++;
    if (fold_count(c, pred)) round_q.push_back(typed ? want : pred);
  endtask

  // Wait for every owed result, then let a possible round in flight finish.
  task automatic drain(input int settle);
    int waited;
    waited = 0;
    while (round_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (round_q.size() != 0) begin
      report("results never delivered", round_q.size(), 0);
      round_q.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  // Write both registers, one per cycle; junk upper bits go with the period count.
  task automatic write_registers(input logic [PER_W-1:0] per, input logic [LIM_W-1:0] lim);
    logic [CFG_DAT_W-PER_W-1:0] junk;
    junk = $urandom_range(0, (1 << (CFG_DAT_W - PER_W)) - 1);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_OSC_PERIODS;
    cfg_wdata <= {junk, per};
    @(posedge clk);
    periods_cfg = per;
    cfg_idx   <= CFG_SPREAD_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    spread_cfg = lim;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Stimulus: directed rows, then phases of random rounds under varied registers.
  // Phases may end mid-round, so a setting can change between counts of one round.
  initial begin
    int          ph;
    int          i;
    int          len;
    logic [3:0]  per;
    logic [15:0] lim;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < 24; i++) send_count(dir_tab[i].count, dir_tab[i].typed, dir_tab[i].want);
    for (ph = 0; ph < PHASES; ph++) begin
      per = $urandom_range(0, 15);
      lim = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
      len = $urandom_range(60, 140);
      case (ph)
        0: begin
          // Accept everything at the smallest divisor; finish the current run.
          per = 4'd1;
          lim = 16'hFFFF;
          len = RUN_LEN - (int'(rnd_idx) * CHANNELS + int'(chan_idx));
        end
        1: begin
          // One whole run in which every round is rejected.
          per = 4'd15;
          lim = 16'd0;
          len = RUN_LEN;
        end
        2: per = 4'd0;  // zero period count acts as a divisor of one
        3: begin
          per = 4'd15;
          lim = 16'hFFFF;
        end
        default: ;
      endcase
      reject_phase = (ph == 1);
      s_tvalid <= 1'b0;
      drain(SETTLE);
      write_registers(per, lim);
      repeat (len) send_count(next_count(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    drain(SETTLE);
    $display("Sent %0d counts under %0d register settings; checked %0d round results.",
             n_counts, n_settings + 1, n_results);
    $display("Saw %0d rejected rounds and %0d finished runs, %0d of them with no good round.",
             n_rejected, n_runs, n_allrej);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: stall at random, take each result transaction, compare with the oldest owed.
  initial begin
    int   stall;
    res_t got;
    res_t want;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) m_burst = ~m_burst;
      stall = m_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      got = '{m_tdata[21:0], m_tdata[22], m_tlast, m_tdata[44:23], m_tdata[45]};
      n_results++;
      if (got.round_rejected) n_rejected++;
      if (got.run_done) n_runs++;
      if (got.run_done && got.all_rejected) n_allrej++;
      if (round_q.size() == 0) begin
        report("result with none owed, round_khz", got.round_khz, 0);
      end else begin
        want = round_q.pop_front();
        if (got.round_khz != want.round_khz)
          report("round_khz", got.round_khz, want.round_khz);
        if (got.round_rejected != want.round_rejected)
          report("round_rejected", got.round_rejected, want.round_rejected);
        if (got.run_done != want.run_done)
          report("run_done", got.run_done, want.run_done);
        if (got.average_khz != want.average_khz)
          report("average_khz", got.average_khz, want.average_khz);
        if (got.all_rejected != want.all_rejected)
          report("all_rejected", got.all_rejected, want.all_rejected);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/ocavg_pkg.sv
src/ocavg_div.sv
src/ocavg_front.sv
src/ocavg_fifo.sv
src/ocavg_back.sv
src/osc_count_calibration_averager.sv
sim/tb.sv
